>>> hw/rtl/cta_pkg.sv
// Shared constants and types of the centroid track associator.
`timescale 1ns / 1ps
package cta_pkg;

	localparam int MAX_TRACKS     = 16;
	localparam int MAX_DETECTIONS = 32;
	localparam int COORD_BITS     = 16;

	localparam int BOX_W   = 16;
	localparam int CLASS_W = 8;
	localparam int SCORE_W = 16;
	localparam int IDENT_W = 32;
	localparam int LOST_W  = 8;
	localparam int THR_W   = 16;

	localparam logic [THR_W-1:0]  THR_RESET   = 16'd19661;
	localparam logic [LOST_W-1:0] LIMIT_RESET = 8'd10;

	// Configuration register indexes.
	localparam logic REG_MATCH_THRESHOLD = 1'b0;
	localparam logic REG_LOST_LIMIT      = 1'b1;

	typedef struct packed {
		logic [BOX_W-1:0]   x;
		logic [BOX_W-1:0]   y;
		logic [BOX_W-1:0]   w;
		logic [BOX_W-1:0]   h;
		logic [CLASS_W-1:0] cls;
		logic [SCORE_W-1:0] score;
	} det_t;

	localparam int DET_W = $bits(det_t);

endpackage

>>> hw/rtl/cta_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module cta_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> hw/rtl/cta_sq_unit.sv
// Shared difference-squaring unit: registers (a - b) squared.
`timescale 1ns / 1ps
module cta_sq_unit #(
	parameter int SQ_W = 17
) (
	input  logic              clk,
	input  logic [SQ_W-1:0]   op_a,
	input  logic [SQ_W-1:0]   op_b,
	output logic [2*SQ_W+1:0] sq_q
);

	logic signed [SQ_W:0]     diff;
	logic signed [2*SQ_W+1:0] prod;

	assign diff = $signed({1'b0, op_a}) - $signed({1'b0, op_b});
	assign prod = diff * diff;

	always_ff @(posedge clk) begin
		sq_q <= $unsigned(prod);
	end

endmodule

>>> hw/rtl/centroid_track_associator.sv
// Top level of the centroid track associator: sequencer, track table and config.
// A detection is taken by start while busy is low and is buffered when det_present is
// set and the buffer has room; the detection that carries frame_end starts frame
// processing, and busy stays high until the last track has been reported. Processing
// runs on one shared squaring unit: setup squares the threshold terms, then each used
// table slot is compared with every buffered detection and takes the best one on a match;
// then, if some detection is left unmatched, each is checked against the used tracks
// and may open a new track; then pruning, and one table scan per reported track, or
// one scan for the single report of an empty table. Results appear on result_strobe
// for one cycle each, in ascending track number, the last with list_end; the receiver
// cannot stall and must take each one.
`timescale 1ns / 1ps
module centroid_track_associator #(
	parameter int MAX_TRACKS     = cta_pkg::MAX_TRACKS,
	parameter int MAX_DETECTIONS = cta_pkg::MAX_DETECTIONS,
	parameter int COORD_BITS     = cta_pkg::COORD_BITS
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        start,
	output logic        busy,
	input  logic        det_present,
	input  logic [15:0] box_left,
	input  logic [15:0] box_top,
	input  logic [15:0] box_width,
	input  logic [15:0] box_height,
	input  logic [7:0]  det_class,
	input  logic [15:0] det_score,
	input  logic        frame_end,

	output logic        result_strobe,
	output logic        track_valid,
	output logic [31:0] track_number,
	output logic [15:0] out_left,
	output logic [15:0] out_top,
	output logic [15:0] out_width,
	output logic [15:0] out_height,
	output logic [7:0]  out_class,
	output logic [15:0] out_score,
	output logic [7:0]  frames_lost,
	output logic        list_end,

	input  logic        wr_en,
	input  logic        wr_index,
	input  logic [15:0] wr_data
);

	localparam int TW   = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
	localparam int AW   = (MAX_DETECTIONS > 1) ? $clog2(MAX_DETECTIONS) : 1;
	localparam int CW   = $clog2(MAX_DETECTIONS + 1);
	localparam int MW   = $clog2(MAX_TRACKS + 1);
	localparam int KW   = (MW > CW) ? MW : CW;
	localparam int SQ_W = ((COORD_BITS > 16) ? COORD_BITS : 16) + 1;
	localparam int PW   = 2 * SQ_W + 2;
	localparam int DW   = PW + 3;
	localparam int UP   = (COORD_BITS >= 16) ? COORD_BITS - 16 : 0;
	localparam int DN   = (COORD_BITS < 16) ? 16 - COORD_BITS : 0;

	localparam logic [15:0] BOX_MASK = (COORD_BITS >= 16) ? 16'hFFFF :
		16'((32'd1 << COORD_BITS) - 32'd1);
	localparam logic [SQ_W-1:0] ONE_C = {{(SQ_W-1){1'b0}}, 1'b1} << COORD_BITS;
	localparam logic [DW-1:0]   HALF2 = {{(DW-1){1'b0}}, 1'b1} << (2 * COORD_BITS);

	typedef enum logic [4:0] {
		S_IDLE, S_PREP_A, S_PREP_T, S_PREP_C,
		S_M_TRK, S_M_RD, S_M_DX, S_M_DY, S_M_CMP, S_M_DEC, S_M_COPY,
		S_N_RD, S_N_DX, S_N_DY, S_N_CMP, S_N_NEW,
		S_PRUNE, S_E_SCAN, S_E_OUT
	} state_t;

	state_t state_q;

	// Configuration.
	logic [15:0] thr_cfg_q;
	logic [7:0]  limit_q;

	// Control.
	logic [CW-1:0]         frame_cnt_q;
	logic [AW-1:0]         j_q;
	logic [TW-1:0]         t_q;
	logic [MW-1:0]         matched_q;
	logic [MW-1:0]         ecnt_q;
	logic                  bestv_q;
	logic                  near_q;
	logic                  pickv_q;
	logic [TW-1:0]         pick_q;
	logic [MAX_TRACKS-1:0] used_q;
	logic [MAX_TRACKS-1:0] done_q;
	logic [31:0]           next_ident_q;

	// Track table payload.
	logic [15:0] sx_q [MAX_TRACKS];
	logic [15:0] sy_q [MAX_TRACKS];
	logic [15:0] sw_q [MAX_TRACKS];
	logic [15:0] sh_q [MAX_TRACKS];
	logic [7:0]  scls_q [MAX_TRACKS];
	logic [15:0] sscore_q [MAX_TRACKS];
	logic [7:0]  slost_q [MAX_TRACKS];
	logic [31:0] sid_q [MAX_TRACKS];

	// Arithmetic and pick registers.
	logic [DW-1:0] acc_q;
	logic [DW-1:0] thr2_q;
	logic [PW-1:0] sqx_q;
	logic [DW-1:0] best_q;
	logic [AW-1:0] best_j_q;
	logic [31:0]   pid_q;
	logic [15:0]   px_q, py_q, pw_q, ph_q, pscore_q;
	logic [7:0]    pcls_q, plost_q;

	logic [31:0] res_number_q;
	logic [15:0] res_left_q, res_top_q, res_width_q, res_height_q, res_score_q;
	logic [7:0]  res_class_q, res_lost_q;
	logic        res_valid_q, res_end_q, strobe_q;

	logic              accept, buf_we, t_last, j_last, cand, take_pick, fetch_ok;
	logic              free_ok;
	logic [TW-1:0]     free_idx;
	logic [SQ_W-1:0]   thr, op_a, op_b;
	logic [PW-1:0]     sq;
	logic [DW-1:0]     dsum, qsum;
	logic [AW-1:0]     raddr;
	cta_pkg::det_t     wdet, rdet;
	logic [cta_pkg::DET_W-1:0] rdata;

	assign accept = start && !busy;
	assign busy   = (state_q != S_IDLE);
	assign buf_we = accept && det_present && (frame_cnt_q < CW'(MAX_DETECTIONS));
	assign t_last = (t_q == TW'(MAX_TRACKS - 1));
	assign j_last = ((CW'(j_q) + CW'(1)) == frame_cnt_q);
	assign thr    = (SQ_W'(thr_cfg_q) << UP) >> DN;
	assign dsum   = DW'(sqx_q) + DW'(sq);
	assign qsum   = dsum << 2;
	assign cand   = used_q[t_q] && !done_q[t_q];
	assign take_pick = cand && (!pickv_q || (sid_q[t_q] < pid_q));
	assign fetch_ok  = bestv_q && (best_q <= acc_q);
	assign rdet   = cta_pkg::det_t'(rdata);
	assign raddr  = (state_q == S_M_DEC) ? best_j_q : j_q;

	assign wdet.x     = box_left & BOX_MASK;
	assign wdet.y     = box_top & BOX_MASK;
	assign wdet.w     = box_width & BOX_MASK;
	assign wdet.h     = box_height & BOX_MASK;
	assign wdet.cls   = det_class;
	assign wdet.score = det_score;

	always_comb begin
		free_ok  = 1'b0;
		free_idx = '0;
		for (int i = MAX_TRACKS - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				free_ok  = 1'b1;
				free_idx = TW'(i);
			end
		end
	end

	always_comb begin
		unique case (state_q)
			S_PREP_A: begin
				op_a = ONE_C;
				op_b = thr;
			end
			S_PREP_T: begin
				op_a = thr;
				op_b = '0;
			end
			S_M_DX, S_N_DX: begin
				op_a = SQ_W'(rdet.x);
				op_b = SQ_W'(sx_q[t_q]);
			end
			S_M_DY, S_N_DY: begin
				op_a = SQ_W'(rdet.y);
				op_b = SQ_W'(sy_q[t_q]);
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	cta_ram #(
		.WIDTH(cta_pkg::DET_W),
		.DEPTH(MAX_DETECTIONS)
	) u_det_buf (
		.clk  (clk),
		.we   (buf_we),
		.waddr(frame_cnt_q[AW-1:0]),
		.wdata(wdet),
		.raddr(raddr),
		.rdata(rdata)
	);

	cta_sq_unit #(
		.SQ_W(SQ_W)
	) u_sq (
		.clk (clk),
		.op_a(op_a),
		.op_b(op_b),
		.sq_q(sq)
	);

	// Sequencer and control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			thr_cfg_q    <= cta_pkg::THR_RESET;
			limit_q      <= cta_pkg::LIMIT_RESET;
			frame_cnt_q  <= '0;
			j_q          <= '0;
			t_q          <= '0;
			matched_q    <= '0;
			ecnt_q       <= '0;
			bestv_q      <= 1'b0;
			near_q       <= 1'b0;
			pickv_q      <= 1'b0;
			pick_q       <= '0;
			used_q       <= '0;
			done_q       <= '0;
			next_ident_q <= '0;
			strobe_q     <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			if (wr_en) begin
				unique case (wr_index)
					cta_pkg::REG_MATCH_THRESHOLD: thr_cfg_q <= wr_data;
					cta_pkg::REG_LOST_LIMIT:      limit_q <= wr_data[7:0];
					default: ;
				endcase
			end
			unique case (state_q)
				S_IDLE: begin
					if (buf_we) begin
						frame_cnt_q <= frame_cnt_q + CW'(1);
					end
					if (accept && frame_end) begin
						state_q <= S_PREP_A;
					end
				end
				S_PREP_A: state_q <= S_PREP_T;
				S_PREP_T: state_q <= S_PREP_C;
				S_PREP_C: begin
					t_q       <= '0;
					matched_q <= '0;
					state_q   <= S_M_TRK;
				end
				S_M_TRK, S_M_DEC, S_M_COPY: begin
					if (state_q == S_M_TRK && used_q[t_q] && frame_cnt_q != '0) begin
						j_q     <= '0;
						bestv_q <= 1'b0;
						state_q <= S_M_RD;
					end else if (state_q == S_M_DEC && fetch_ok) begin
						matched_q <= matched_q + MW'(1);
						state_q   <= S_M_COPY;
					end else if (t_last) begin
						j_q <= '0;
						state_q <= (KW'(matched_q) < KW'(frame_cnt_q)) ? S_N_RD : S_PRUNE;
					end else begin
						t_q     <= t_q + TW'(1);
						state_q <= S_M_TRK;
					end
				end
				S_M_RD: state_q <= S_M_DX;
				S_M_DX: state_q <= S_M_DY;
				S_M_DY: state_q <= S_M_CMP;
				S_M_CMP: begin
					if (qsum < HALF2 && (!bestv_q || qsum < best_q)) begin
						bestv_q <= 1'b1;
					end
					if (j_last) begin
						state_q <= S_M_DEC;
					end else begin
						j_q     <= j_q + AW'(1);
						state_q <= S_M_RD;
					end
				end
				S_N_RD: begin
					t_q     <= '0;
					near_q  <= 1'b0;
					state_q <= S_N_DX;
				end
				S_N_DX: begin
					if (used_q[t_q]) begin
						state_q <= S_N_DY;
					end else if (t_last) begin
						state_q <= S_N_NEW;
					end else begin
						t_q <= t_q + TW'(1);
					end
				end
				S_N_DY: state_q <= S_N_CMP;
				S_N_CMP: begin
					if (dsum < thr2_q) begin
						near_q  <= 1'b1;
						state_q <= S_N_NEW;
					end else if (t_last) begin
						state_q <= S_N_NEW;
					end else begin
						t_q     <= t_q + TW'(1);
						state_q <= S_N_DX;
					end
				end
				S_N_NEW: begin
					if (!near_q && free_ok) begin
						used_q[free_idx] <= 1'b1;
						next_ident_q     <= next_ident_q + 32'd1;
					end
					if (j_last) begin
						state_q <= S_PRUNE;
					end else begin
						j_q     <= j_q + AW'(1);
						state_q <= S_N_RD;
					end
				end
				S_PRUNE: begin
					for (int i = 0; i < MAX_TRACKS; i++) begin
						if (used_q[i] && slost_q[i] > limit_q) begin
							used_q[i] <= 1'b0;
						end
					end
					frame_cnt_q <= '0;
					done_q      <= '0;
					t_q         <= '0;
					pickv_q     <= 1'b0;
					ecnt_q      <= '0;
					state_q     <= S_E_SCAN;
				end
				S_E_SCAN: begin
					if (cand) begin
						ecnt_q <= ecnt_q + MW'(1);
					end
					if (take_pick) begin
						pickv_q <= 1'b1;
						pick_q  <= t_q;
					end
					if (t_last) begin
						state_q <= S_E_OUT;
					end else begin
						t_q <= t_q + TW'(1);
					end
				end
				S_E_OUT: begin
					strobe_q <= 1'b1;
					if (!pickv_q || ecnt_q == MW'(1)) begin
						state_q <= S_IDLE;
					end else begin
						done_q[pick_q] <= 1'b1;
						t_q     <= '0;
						pickv_q <= 1'b0;
						ecnt_q  <= '0;
						state_q <= S_E_SCAN;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Track table, arithmetic and result payload.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_PREP_T: acc_q <= DW'(sq);
			S_PREP_C: thr2_q <= DW'(sq);
			S_M_TRK: begin
				if (used_q[t_q] && frame_cnt_q == '0) begin
					slost_q[t_q] <= (slost_q[t_q] == 8'hFF) ? slost_q[t_q]
						: slost_q[t_q] + 8'd1;
				end
			end
			S_M_DY, S_N_DY: sqx_q <= sq;
			S_M_CMP: begin
				if (qsum < HALF2 && (!bestv_q || qsum < best_q)) begin
					best_q   <= qsum;
					best_j_q <= j_q;
				end
			end
			S_M_DEC: begin
				if (!fetch_ok) begin
					slost_q[t_q] <= (slost_q[t_q] == 8'hFF) ? slost_q[t_q]
						: slost_q[t_q] + 8'd1;
				end
			end
			S_M_COPY: begin
				sx_q[t_q]     <= rdet.x;
				sy_q[t_q]     <= rdet.y;
				sw_q[t_q]     <= rdet.w;
				sh_q[t_q]     <= rdet.h;
				scls_q[t_q]   <= rdet.cls;
				sscore_q[t_q] <= rdet.score;
				slost_q[t_q]  <= '0;
			end
			S_N_NEW: begin
				if (!near_q && free_ok) begin
					sid_q[free_idx]    <= next_ident_q;
					sx_q[free_idx]     <= rdet.x;
					sy_q[free_idx]     <= rdet.y;
					sw_q[free_idx]     <= rdet.w;
					sh_q[free_idx]     <= rdet.h;
					scls_q[free_idx]   <= rdet.cls;
					sscore_q[free_idx] <= rdet.score;
					slost_q[free_idx]  <= '0;
				end
			end
			S_E_SCAN: begin
				// The candidate's fields are copied as the scan goes, so the table
				// is read only at the scan index.
				if (take_pick) begin
					pid_q    <= sid_q[t_q];
					px_q     <= sx_q[t_q];
					py_q     <= sy_q[t_q];
					pw_q     <= sw_q[t_q];
					ph_q     <= sh_q[t_q];
					pcls_q   <= scls_q[t_q];
					pscore_q <= sscore_q[t_q];
					plost_q  <= slost_q[t_q];
				end
			end
			S_E_OUT: begin
				res_valid_q  <= pickv_q;
				res_end_q    <= !pickv_q || ecnt_q == MW'(1);
				res_number_q <= pickv_q ? pid_q : '0;
				res_left_q   <= pickv_q ? px_q : '0;
				res_top_q    <= pickv_q ? py_q : '0;
				res_width_q  <= pickv_q ? pw_q : '0;
				res_height_q <= pickv_q ? ph_q : '0;
				res_class_q  <= pickv_q ? pcls_q : '0;
				res_score_q  <= pickv_q ? pscore_q : '0;
				res_lost_q   <= pickv_q ? plost_q : '0;
			end
			default: ;
		endcase
	end

	assign result_strobe = strobe_q;
	assign track_valid   = res_valid_q;
	assign track_number  = res_number_q;
	assign out_left      = res_left_q;
	assign out_top       = res_top_q;
	assign out_width     = res_width_q;
	assign out_height    = res_height_q;
	assign out_class     = res_class_q;
	assign out_score     = res_score_q;
	assign frames_lost   = res_lost_q;
	assign list_end      = res_end_q;

endmodule

>>> bench/centroid_track_associator_test.sv
// Self-checking testbench of the centroid track associator: predicted track lists per frame.
`timescale 1ns / 1ps
module centroid_track_associator_test;

	typedef struct packed {
		logic        valid;
		logic [31:0] number;
		logic [15:0] left, top, width, height;
		logic [7:0]  cls;
		logic [15:0] score;
		logic [7:0]  lost;
		logic        last;
	} track_rpt_t;

	// Keeps its own copy of the track table and checks each reported track in order.
	class track_table_board;
		bit             used[cta_pkg::MAX_TRACKS];
		bit [31:0]      ident[cta_pkg::MAX_TRACKS];
		bit [15:0]      bx[cta_pkg::MAX_TRACKS][4];
		bit [7:0]       tcls[cta_pkg::MAX_TRACKS];
		bit [15:0]      tscore[cta_pkg::MAX_TRACKS];
		bit [7:0]       lost[cta_pkg::MAX_TRACKS];
		cta_pkg::det_t  buffered[cta_pkg::MAX_DETECTIONS];
		int             nbuf;
		bit [31:0]      next_id;
		bit [15:0]      threshold = cta_pkg::THR_RESET;
		bit [7:0]       limit = cta_pkg::LIMIT_RESET;
		track_rpt_t     pending[$];
		int             mismatches;
		int             frames;
		int             reports;

		function bit [63:0] sqdist(bit [15:0] ax, bit [15:0] ay, bit [15:0] bx2, bit [15:0] by);
			longint dx, dy;
			dx = longint'(ax) - longint'(bx2);
			dy = longint'(ay) - longint'(by);
			return dx * dx + dy * dy;
		endfunction

		function void note_detection(cta_pkg::det_t d, bit present, bit fin);
			if (present && nbuf < cta_pkg::MAX_DETECTIONS) begin
				buffered[nbuf] = d;
				nbuf++;
			end
			if (fin) begin
				close_frame();
			end
		endfunction

		function void close_frame();
			bit [63:0] one_c, thr, accept, half2, best, q;
			int best_j, matched, slot, added;
			bit near, seen[cta_pkg::MAX_TRACKS];
			track_rpt_t r;
			one_c = 64'd1 << 16;
			thr = threshold;
			accept = (one_c > thr) ? (one_c - thr) * (one_c - thr) : 0;
			half2 = one_c * one_c;
			matched = 0;
			for (int t = 0; t < cta_pkg::MAX_TRACKS; t++) begin
				if (!used[t]) continue;
				best_j = -1;
				best = 0;
				for (int j = 0; j < nbuf; j++) begin
					q = 4 * sqdist(buffered[j].x, buffered[j].y, bx[t][0], bx[t][1]);
					if (q < half2 && (best_j < 0 || q < best)) begin
						best = q;
						best_j = j;
					end
				end
				if (best_j >= 0 && one_c > thr && best <= accept) begin
					take_box(t, buffered[best_j]);
					matched++;
				end else if (lost[t] != 8'd255) begin
					lost[t]++;
				end
			end
			if (matched < nbuf) begin
				for (int j = 0; j < nbuf; j++) begin
					near = 0;
					for (int t = 0; t < cta_pkg::MAX_TRACKS; t++)
						if (used[t] && sqdist(buffered[j].x, buffered[j].y,
								bx[t][0], bx[t][1]) < thr * thr)
							near = 1;
					if (near) continue;
					slot = -1;
					for (int t = cta_pkg::MAX_TRACKS - 1; t >= 0; t--)
						if (!used[t]) slot = t;
					if (slot < 0) continue;
					used[slot] = 1;
					ident[slot] = next_id;
					next_id++;
					take_box(slot, buffered[j]);
				end
			end
			for (int t = 0; t < cta_pkg::MAX_TRACKS; t++)
				if (used[t] && lost[t] > limit) used[t] = 0;
			nbuf = 0;
			frames++;
			added = 0;
			foreach (seen[t]) seen[t] = 0;
			forever begin
				slot = -1;
				for (int t = 0; t < cta_pkg::MAX_TRACKS; t++)
					if (used[t] && !seen[t] && (slot < 0 || ident[t] < ident[slot]))
						slot = t;
				if (slot < 0) break;
				seen[slot] = 1;
				r = '{1'b1, ident[slot], bx[slot][0], bx[slot][1], bx[slot][2],
					bx[slot][3], tcls[slot], tscore[slot], lost[slot], 1'b0};
				pending = {pending, r};
				added++;
			end
			// An empty table still reports one entry for the frame.
			if (added == 0) begin
				r = '0;
				pending = {pending, r};
			end
			pending[$].last = 1'b1;
		endfunction

		function void take_box(int t, cta_pkg::det_t d);
			bx[t][0] = d.x; bx[t][1] = d.y; bx[t][2] = d.w; bx[t][3] = d.h;
			tcls[t] = d.cls; tscore[t] = d.score; lost[t] = 0;
		endfunction

		function void check_report(track_rpt_t got);
			track_rpt_t want;
			reports++;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected track report %p", got);
				return;
			end
			want = pending.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10) $display("track report mismatch: want %p got %p", want, got);
			end
		endfunction
	endclass

	logic clk, arst_n, start, busy, det_present, frame_end;
	logic [15:0] box_left, box_top, box_width, box_height, det_score;
	logic [7:0] det_class;
	logic result_strobe, track_valid, list_end, wr_en, wr_index;
	logic [31:0] track_number;
	logic [15:0] out_left, out_top, out_width, out_height, out_score, wr_data;
	logic [7:0] out_class, frames_lost;

	track_table_board board;
	int idle_cycles;

	centroid_track_associator u_dut (.*);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		if (result_strobe) begin
			board.check_report('{track_valid, track_number, out_left, out_top, out_width,
				out_height, out_class, out_score, frames_lost, list_end});
		end
		if ((start && !busy) || result_strobe) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 20000) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Start stays high into the next item when no idle cycles are drawn after a transfer.
	task automatic send_det(bit present, cta_pkg::det_t d, bit fin);
		int gap;
		start <= 1;
		det_present <= present;
		box_left <= d.x; box_top <= d.y; box_width <= d.w; box_height <= d.h;
		det_class <= d.cls; det_score <= d.score;
		frame_end <= fin;
		do @(posedge clk); while (busy);
		board.note_detection(d, present, fin);
		gap = $urandom_range(0, 18);
		if (gap != 0) begin
			start <= 0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic settle();
		start <= 0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [15:0] val);
		wr_en <= 1; wr_index <= idx; wr_data <= val;
		@(posedge clk);
		wr_en <= 0;
		if (idx == cta_pkg::REG_MATCH_THRESHOLD) board.threshold = val;
		else board.limit = val[7:0];
	endtask

	function automatic cta_pkg::det_t rand_det(bit wide);
		cta_pkg::det_t d;
		d = cta_pkg::det_t'(88'({$urandom, $urandom, $urandom}));
		if (!wide) begin
			// Clustered positions keep tracks matching across frames.
			d.x = 16'd4000 + 16'($urandom_range(0, 7)) * 16'd7000 + 16'($urandom_range(0, 900));
			d.y = 16'd4000 + 16'($urandom_range(0, 7)) * 16'd7000 + 16'($urandom_range(0, 900));
		end
		return d;
	endfunction

	task automatic rand_frame(int ndet);
		for (int i = 0; i < ndet; i++)
			send_det($urandom_range(0, 9) != 0, rand_det($urandom_range(0, 5) == 0),
				i == ndet - 1);
	endtask

	initial begin
		cta_pkg::det_t d;
		int sent;
		board = new();
		idle_cycles = 0;
		start = 0; det_present = 0; frame_end = 0;
		box_left = 0; box_top = 0; box_width = 0; box_height = 0;
		det_class = 0; det_score = 0;
		wr_en = 0; wr_index = cta_pkg::REG_MATCH_THRESHOLD; wr_data = 0;
		arst_n = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Empty table, then extremes of every field and an empty frame.
		send_det(0, '0, 1);
		send_det(1, '0, 0);
		send_det(1, '1, 0);
		send_det(1, {16'h8000, 16'h0000, 16'hffff, 16'h0001, 8'h5a, 16'ha5a5}, 1);
		send_det(1, {16'h0010, 16'h0010, 16'h1234, 16'h4321, 8'h01, 16'h0002}, 1);
		send_det(0, '1, 1);
		settle();
		write_reg(cta_pkg::REG_LOST_LIMIT, 16'd0);
		write_reg(cta_pkg::REG_MATCH_THRESHOLD, 16'd0);
		send_det(1, {16'd100, 16'd100, 16'd5, 16'd5, 8'd3, 16'd7}, 1);
		send_det(0, '0, 1);
		settle();
		write_reg(cta_pkg::REG_MATCH_THRESHOLD, 16'hffff);
		write_reg(cta_pkg::REG_LOST_LIMIT, 16'hff);
		// Overfill the detection buffer with boxes spread apart along x.
		for (int i = 0; i < 34; i++) begin
			d = rand_det(1);
			d.x = 16'(i * 1900);
			send_det(1, d, i == 33);
		end
		settle();
		write_reg(cta_pkg::REG_MATCH_THRESHOLD, cta_pkg::THR_RESET);
		write_reg(cta_pkg::REG_LOST_LIMIT, 16'd3);
		send_det(0, '0, 1);

		sent = 0;
		for (int ph = 0; ph < 4; ph++) begin
			settle();
			case (ph)
				0: begin
					write_reg(cta_pkg::REG_MATCH_THRESHOLD, 16'd3000);
					write_reg(cta_pkg::REG_LOST_LIMIT, 16'd2);
				end
				1: begin
					write_reg(cta_pkg::REG_MATCH_THRESHOLD, cta_pkg::THR_RESET);
					write_reg(cta_pkg::REG_LOST_LIMIT, 16'd10);
				end
				2: begin
					write_reg(cta_pkg::REG_MATCH_THRESHOLD, 16'd40000);
					write_reg(cta_pkg::REG_LOST_LIMIT, 16'd1);
				end
				default: begin
					write_reg(cta_pkg::REG_MATCH_THRESHOLD, 16'd9000);
					write_reg(cta_pkg::REG_LOST_LIMIT, 16'd255);
				end
			endcase
			while (sent < (ph + 1) * 102) begin
				int n;
				n = $urandom_range(1, 6);
				rand_frame(n);
				sent += n;
			end
		end
		settle();
		$display("Ran %0d frames with %0d track reports checked; %0d mismatches.",
			board.frames, board.reports, board.mismatches);
		if (board.mismatches == 0 && board.pending.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule

>>> files.f
hw/rtl/cta_pkg.sv
hw/rtl/cta_ram.sv
hw/rtl/cta_sq_unit.sv
hw/rtl/centroid_track_associator.sv
bench/centroid_track_associator_test.sv
